// File: hdl/ecc_pkg.sv
`timescale 1ns / 1ps

package ecc_pkg;

    localparam int FLOOR_COUNT = 16;
    localparam int FLOOR_W     = $clog2(FLOOR_COUNT);
    localparam int TIMER_W     = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int KIND_W      = 3;
    localparam int REQ_W       = 8;

    localparam logic [CFG_W-1:0] DEPARTURE_RESET = CFG_W'(1000);
    localparam logic [CFG_W-1:0] TRAVEL_RESET    = CFG_W'(2000);
    localparam logic [CFG_W-1:0] DOOR_ACK_RESET  = CFG_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPARTURE_PERIOD = 2'd0,
        REG_TRAVEL_PERIOD    = 2'd1,
        REG_DOOR_ACK_TIMEOUT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        MODE_STOP  = 3'd0,
        MODE_UP    = 3'd1,
        MODE_DOWN  = 3'd2,
        MODE_EMERG = 3'd3,
        MODE_DOORS = 3'd4
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK        = 3'd0,
        KIND_DOOR_OPENED = 3'd1,
        KIND_DOOR_CLOSED = 3'd2,
        KIND_NEW_TARGET  = 3'd3,
        KIND_OPEN_DOORS  = 3'd4,
        KIND_TEST_OPEN   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MOTOR_NONE  = 3'd0,
        MOTOR_UP    = 3'd1,
        MOTOR_DOWN  = 3'd2,
        MOTOR_STOP  = 3'd3,
        MOTOR_BRAKE = 3'd4
    } motor_t;

    typedef struct packed {
        mode_t              mode;
        logic [FLOOR_W-1:0] floor_now;
        logic [FLOOR_W-1:0] floor_goal;
        logic               door_wait;
        logic               goal_changed;
        logic               started;
        logic [TIMER_W-1:0] dep_cnt;
        logic               dep_run;
        logic [TIMER_W-1:0] tr_cnt;
        logic               tr_run;
        logic [TIMER_W-1:0] wd_cnt;
        logic               wd_run;
    } ecc_state_t;

    typedef struct packed {
        motor_t             motor_cmd;
        logic               door_open_cmd;
        logic               floor_report_valid;
        logic [FLOOR_W-1:0] reported_floor;
        logic               arrived;
        logic               brake_engaged;
        mode_t              mode_now;
    } ecc_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] departure_period;
        logic [CFG_W-1:0] floor_travel_period;
        logic [CFG_W-1:0] door_ack_timeout;
    } ecc_cfg_t;

endpackage

// File: hdl/ecc_if.sv
`timescale 1ns / 1ps

interface ecc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] requested_floor;

    modport source (output valid, output kind, output requested_floor, input ready);
    modport sink (input valid, input kind, input requested_floor, output ready);
endinterface

interface ecc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] motor_cmd;
    logic       door_open_cmd;
    logic       floor_report_valid;
    logic [3:0] reported_floor;
    logic       arrived;
    logic       brake_engaged;
    logic [2:0] mode_now;

    modport source (output valid, output motor_cmd, output door_open_cmd,
                    output floor_report_valid, output reported_floor, output arrived,
                    output brake_engaged, output mode_now, input ready);
    modport sink (input valid, input motor_cmd, input door_open_cmd,
                  input floor_report_valid, input reported_floor, input arrived,
                  input brake_engaged, input mode_now, output ready);
endinterface

// File: hdl/ecc_timer.sv
`timescale 1ns / 1ps

module ecc_timer (
    input  logic [ecc_pkg::TIMER_W-1:0] cnt,
    input  logic                        run,
    input  logic [ecc_pkg::CFG_W-1:0]   period,
    output logic [ecc_pkg::TIMER_W-1:0] cnt_next,
    output logic                        expired
);
    import ecc_pkg::*;

    localparam logic [TIMER_W-1:0] CNT_FULL = '1;

    logic [TIMER_W-1:0] cnt_inc;

    // The count saturates at full scale, which also counts as an expiry.
    // A period of zero expires on every tick, the same as a period of one.
    always_comb
    begin
        cnt_inc  = (cnt < CNT_FULL) ? cnt + 1'b1 : cnt;
        cnt_next = cnt;
        expired  = 1'b0;
        if (run)
        begin
            if (cnt_inc >= period || cnt_inc == CNT_FULL)
            begin
                cnt_next = '0;
                expired  = 1'b1;
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

endmodule

// File: hdl/ecc_step.sv
`timescale 1ns / 1ps

module ecc_step (
    input  ecc_pkg::ecc_state_t             state_cur,
    input  ecc_pkg::ecc_cfg_t               cfg,
    input  logic [ecc_pkg::KIND_W-1:0]      kind,
    input  logic [ecc_pkg::REQ_W-1:0]       requested_floor,
    output ecc_pkg::ecc_state_t             state_next,
    output ecc_pkg::ecc_result_t            res
);
    import ecc_pkg::*;

    typedef struct packed {
        ecc_state_t  st;
        ecc_result_t r;
    } ctx_t;

    function automatic ctx_t enter_stopped(ctx_t c);
        ctx_t o;
        o = c;
        o.st.mode = MODE_STOP;
        if (c.st.goal_changed)
        begin
            o.st.goal_changed = 1'b0;
        end
        else if (!c.st.door_wait)
        begin
            o.r.door_open_cmd = 1'b1;
            o.st.door_wait    = 1'b1;
            o.st.wd_cnt       = '0;
            o.st.wd_run       = 1'b1;
        end
        else
        begin
            o.st.door_wait = 1'b0;
        end
        return o;
    endfunction

    function automatic ctx_t enter_up(ctx_t c);
        ctx_t o;
        o = c;
        o.st.mode = MODE_UP;
        if (int'(c.st.floor_now) + 1 < FLOOR_COUNT)
        begin
            o.st.floor_now = c.st.floor_now + 1'b1;
        end
        o.r.floor_report_valid = 1'b1;
        return o;
    endfunction

    function automatic ctx_t enter_down(ctx_t c);
        ctx_t o;
        o = c;
        o.st.mode = MODE_DOWN;
        if (c.st.floor_now != '0)
        begin
            o.st.floor_now = c.st.floor_now - 1'b1;
        end
        o.r.floor_report_valid = 1'b1;
        return o;
    endfunction

    function automatic ctx_t enter_emergency(ctx_t c);
        ctx_t o;
        o = c;
        o.st.mode          = MODE_EMERG;
        o.r.motor_cmd      = MOTOR_BRAKE;
        o.r.brake_engaged  = 1'b1;
        return o;
    endfunction

    function automatic ctx_t brake_while_moving(ctx_t c);
        ctx_t o;
        o = c;
        o.st.tr_run  = 1'b0;
        o.st.dep_run = 1'b0;
        return enter_emergency(o);
    endfunction

    function automatic ctx_t set_goal(ctx_t c, logic [REQ_W-1:0] f);
        ctx_t o;
        o = c;
        if (int'(f) < FLOOR_COUNT)
        begin
            o.st.floor_goal = f[FLOOR_W-1:0];
        end
        return o;
    endfunction

    ctx_t               ctx_entry;
    ctx_t               ctx_work;
    logic [TIMER_W-1:0] wd_cnt_adv;
    logic [TIMER_W-1:0] dep_cnt_adv;
    logic [TIMER_W-1:0] tr_cnt_adv;
    logic               wd_exp;
    logic               dep_exp;
    logic               tr_exp;

    // The stopped mode is entered once, ahead of the first item after reset.
    always_comb
    begin
        ctx_entry.st                   = state_cur;
        ctx_entry.r.motor_cmd          = MOTOR_NONE;
        ctx_entry.r.door_open_cmd      = 1'b0;
        ctx_entry.r.floor_report_valid = 1'b0;
        ctx_entry.r.reported_floor     = '0;
        ctx_entry.r.arrived            = 1'b0;
        ctx_entry.r.brake_engaged      = 1'b0;
        ctx_entry.r.mode_now           = MODE_STOP;
        if (!state_cur.started)
        begin
            ctx_entry.st.started = 1'b1;
            ctx_entry            = enter_stopped(ctx_entry);
        end
    end

    ecc_timer u_wd_timer (
        .cnt      (ctx_entry.st.wd_cnt),
        .run      (ctx_entry.st.wd_run),
        .period   (cfg.door_ack_timeout),
        .cnt_next (wd_cnt_adv),
        .expired  (wd_exp)
    );

    ecc_timer u_dep_timer (
        .cnt      (ctx_entry.st.dep_cnt),
        .run      (ctx_entry.st.dep_run),
        .period   (cfg.departure_period),
        .cnt_next (dep_cnt_adv),
        .expired  (dep_exp)
    );

    ecc_timer u_tr_timer (
        .cnt      (ctx_entry.st.tr_cnt),
        .run      (ctx_entry.st.tr_run),
        .period   (cfg.floor_travel_period),
        .cnt_next (tr_cnt_adv),
        .expired  (tr_exp)
    );

    always_comb
    begin
        ctx_work = ctx_entry;
        unique case (kind)
            KIND_TICK:
            begin
                ctx_work.st.wd_cnt  = wd_cnt_adv;
                ctx_work.st.dep_cnt = dep_cnt_adv;
                ctx_work.st.tr_cnt  = tr_cnt_adv;
                // Expiries act in the order watchdog, departure, travel, each
                // seeing the mode and run flags left by the one before.
                if (wd_exp)
                begin
                    ctx_work.st.wd_run = 1'b0;
                    if (ctx_work.st.mode == MODE_STOP)
                    begin
                        ctx_work.st.dep_run = 1'b0;
                        ctx_work            = enter_emergency(ctx_work);
                    end
                end
                if (dep_exp && ctx_work.st.dep_run && ctx_work.st.mode == MODE_STOP)
                begin
                    if (ctx_work.st.floor_goal > ctx_work.st.floor_now)
                    begin
                        ctx_work.st.tr_cnt  = '0;
                        ctx_work.st.tr_run  = 1'b1;
                        ctx_work.r.motor_cmd = MOTOR_UP;
                        ctx_work            = enter_up(ctx_work);
                    end
                    else if (ctx_work.st.floor_goal < ctx_work.st.floor_now)
                    begin
                        ctx_work.st.tr_cnt  = '0;
                        ctx_work.st.tr_run  = 1'b1;
                        ctx_work.r.motor_cmd = MOTOR_DOWN;
                        ctx_work            = enter_down(ctx_work);
                    end
                end
                if (tr_exp && ctx_work.st.tr_run &&
                    (ctx_work.st.mode == MODE_UP || ctx_work.st.mode == MODE_DOWN))
                begin
                    if (ctx_work.st.floor_now == ctx_work.st.floor_goal)
                    begin
                        ctx_work.st.tr_run   = 1'b0;
                        ctx_work.r.motor_cmd = MOTOR_STOP;
                        ctx_work.r.arrived   = 1'b1;
                        ctx_work             = enter_stopped(ctx_work);
                    end
                    else if (ctx_work.st.mode == MODE_UP)
                    begin
                        ctx_work = enter_up(ctx_work);
                    end
                    else
                    begin
                        ctx_work = enter_down(ctx_work);
                    end
                end
            end
            KIND_DOOR_OPENED:
            begin
                if (ctx_work.st.mode == MODE_STOP)
                begin
                    if (ctx_work.st.door_wait)
                    begin
                        ctx_work.st.wd_run = 1'b0;
                        ctx_work.st.mode   = MODE_DOORS;
                    end
                end
                else if (ctx_work.st.mode == MODE_UP || ctx_work.st.mode == MODE_DOWN)
                begin
                    ctx_work = brake_while_moving(ctx_work);
                end
            end
            KIND_DOOR_CLOSED:
            begin
                if (ctx_work.st.mode == MODE_DOORS)
                begin
                    ctx_work = enter_stopped(ctx_work);
                end
            end
            KIND_NEW_TARGET:
            begin
                if (ctx_work.st.mode == MODE_STOP)
                begin
                    ctx_work                 = set_goal(ctx_work, requested_floor);
                    ctx_work.st.goal_changed = 1'b1;
                    ctx_work                 = enter_stopped(ctx_work);
                end
                else if (ctx_work.st.mode == MODE_UP)
                begin
                    ctx_work = enter_up(set_goal(ctx_work, requested_floor));
                end
                else if (ctx_work.st.mode == MODE_DOWN)
                begin
                    ctx_work = enter_down(set_goal(ctx_work, requested_floor));
                end
                else if (ctx_work.st.mode == MODE_DOORS)
                begin
                    ctx_work = set_goal(ctx_work, requested_floor);
                end
            end
            KIND_OPEN_DOORS:
            begin
                if (ctx_work.st.mode == MODE_STOP)
                begin
                    ctx_work = enter_stopped(ctx_work);
                end
            end
            KIND_TEST_OPEN:
            begin
                if (ctx_work.st.mode == MODE_UP || ctx_work.st.mode == MODE_DOWN)
                begin
                    ctx_work = brake_while_moving(ctx_work);
                end
            end
            default:
            begin
                ctx_work = ctx_entry;
            end
        endcase
    end

    always_comb
    begin
        state_next         = ctx_work.st;
        res                = ctx_work.r;
        res.reported_floor = ctx_work.st.floor_now;
        res.mode_now       = ctx_work.st.mode;
    end

endmodule

// File: hdl/elevator_car_controller_core.sv
`timescale 1ns / 1ps

// Controller for one elevator car. It takes one item (a tick or an event)
// per clock cycle while the result side does not stall, and returns exactly
// one result for each. An item is held in an input register, the whole state
// update for it is one pass of combinational logic, and the result lands in
// an output register, where it is offered. The request side stays ready while
// the input register is empty, or the output register is empty or is being
// emptied in the same cycle; a stalled result therefore holds at most one
// more item in the input register. Timer periods must be written through the
// cfg port only while no item is in flight; the user is bound to this, and
// the block itself does not enforce it.

module elevator_car_controller_core (
    input  logic                             clk,
    input  logic                             rst_n,
    ecc_in_if.sink                           request,
    ecc_out_if.source                        result,
    input  logic                             cfg_write,
    input  logic [ecc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ecc_pkg::CFG_W-1:0]        cfg_data
);
    import ecc_pkg::*;

    ecc_cfg_t           cfg_reg;
    ecc_state_t         state_reg;
    ecc_state_t         state_next;
    ecc_result_t        res_next;
    ecc_result_t        res_reg;
    logic               in_valid_reg;
    logic [KIND_W-1:0]  in_kind_reg;
    logic [REQ_W-1:0]   in_floor_reg;
    logic               out_valid_reg;
    logic               advance;

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign request.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.departure_period    <= DEPARTURE_RESET;
            cfg_reg.floor_travel_period <= TRAVEL_RESET;
            cfg_reg.door_ack_timeout    <= DOOR_ACK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEPARTURE_PERIOD: cfg_reg.departure_period    <= cfg_data;
                REG_TRAVEL_PERIOD:    cfg_reg.floor_travel_period <= cfg_data;
                REG_DOOR_ACK_TIMEOUT: cfg_reg.door_ack_timeout    <= cfg_data;
                default:              cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            in_kind_reg  <= request.kind;
            in_floor_reg <= request.requested_floor;
        end
    end

    ecc_step u_step (
        .state_cur       (state_reg),
        .cfg             (cfg_reg),
        .kind            (in_kind_reg),
        .requested_floor (in_floor_reg),
        .state_next      (state_next),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_STOP;
            state_reg.floor_now    <= '0;
            state_reg.floor_goal   <= '0;
            state_reg.door_wait    <= 1'b0;
            state_reg.goal_changed <= 1'b0;
            state_reg.started      <= 1'b0;
            state_reg.dep_cnt      <= '0;
            state_reg.dep_run      <= 1'b1;
            state_reg.tr_cnt       <= '0;
            state_reg.tr_run       <= 1'b0;
            state_reg.wd_cnt       <= '0;
            state_reg.wd_run       <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.motor_cmd          = res_reg.motor_cmd;
    assign result.door_open_cmd      = res_reg.door_open_cmd;
    assign result.floor_report_valid = res_reg.floor_report_valid;
    assign result.reported_floor     = res_reg.reported_floor;
    assign result.arrived            = res_reg.arrived;
    assign result.brake_engaged      = res_reg.brake_engaged;
    assign result.mode_now           = res_reg.mode_now;

    // An emergency entered on an item cannot be left later in the same item.
    a_brake_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.brake_engaged) |-> (res_reg.mode_now == MODE_EMERG))
        else $error("brake reported outside emergency mode");

    // Arrival always stops the motor and leaves the car in the stopped mode.
    a_arrival: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.arrived) |->
            (res_reg.motor_cmd == MOTOR_STOP && res_reg.mode_now == MODE_STOP))
        else $error("arrival without stop");

    // The car state only changes when an item is handed to the output register.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // A result waiting on the output side keeps all its fields until taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

// File: tb/tb_elevator_car_controller_core.sv
`timescale 1ns / 1ps

module tb_elevator_car_controller_core;
    import ecc_pkg::*;

    localparam logic [KIND_W-1:0]  KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0]  KIND_SPARE_B = 3'd7;
    localparam logic [FLOOR_W-1:0] TOP_FLOOR    = FLOOR_W'(FLOOR_COUNT - 1);
    localparam logic [TIMER_W-1:0] TIMER_FULL   = '1;
    localparam logic [CFG_W-1:0]   CFG_MAX      = '1;
    localparam int                 HOLD_CYCLES  = 80;

    localparam int ROUTE_WATCHDOG  = 0;
    localparam int ROUTE_DOOR_OPEN = 1;
    localparam int ROUTE_TEST_OPEN = 2;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ecc_in_if  req_if ();
    ecc_out_if res_if ();

    elevator_car_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_if),
        .result    (res_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Car state as predicted from the accepted items.
    mode_t                car_mode;
    logic [FLOOR_W-1:0]   car_floor;
    logic [FLOOR_W-1:0]   car_goal;
    bit                   door_pending;
    bit                   goal_fresh;
    bit                   powered_up;
    logic [TIMER_W-1:0]   dep_cnt;
    logic [TIMER_W-1:0]   tr_cnt;
    logic [TIMER_W-1:0]   wd_cnt;
    bit                   dep_on;
    bit                   tr_on;
    bit                   wd_on;
    logic [CFG_W-1:0]     cfg_dep;
    logic [CFG_W-1:0]     cfg_tr;
    logic [CFG_W-1:0]     cfg_wd;
    ecc_result_t          car_result;

    ecc_result_t expected_results[$];
    int          mismatch_count = 0;
    bit          steady = 1'b0;
    bit          rush = 1'b0;
    bit          hold_request = 1'b0;

    function automatic void reset_car_model();
        car_mode     = MODE_STOP;
        car_floor    = '0;
        car_goal     = '0;
        door_pending = 1'b0;
        goal_fresh   = 1'b0;
        powered_up   = 1'b0;
        dep_cnt      = '0;
        tr_cnt       = '0;
        wd_cnt       = '0;
        dep_on       = 1'b1;
        tr_on        = 1'b0;
        wd_on        = 1'b0;
        cfg_dep      = DEPARTURE_RESET;
        cfg_tr       = TRAVEL_RESET;
        cfg_wd       = DOOR_ACK_RESET;
    endfunction

    function automatic bit car_moving();
        return car_mode == MODE_UP || car_mode == MODE_DOWN;
    endfunction

    // A zero period expires on every tick, the same as a period of one.
    function automatic bit timer_expired(inout logic [TIMER_W-1:0] cnt, inout bit run,
                                         input logic [CFG_W-1:0] period);
        if (!run)
            return 1'b0;
        if (cnt != TIMER_FULL)
            cnt++;
        if (cnt >= period || cnt == TIMER_FULL)
        begin
            cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter_stopped_mode();
        car_mode = MODE_STOP;
        if (goal_fresh)
            goal_fresh = 1'b0;
        else if (!door_pending)
        begin
            car_result.door_open_cmd = 1'b1;
            door_pending = 1'b1;
            wd_cnt = '0;
            wd_on = 1'b1;
        end
        else
            door_pending = 1'b0;
    endfunction

    function automatic void step_up();
        car_mode = MODE_UP;
        if (car_floor != TOP_FLOOR)
            car_floor++;
        car_result.floor_report_valid = 1'b1;
    endfunction

    function automatic void step_down();
        car_mode = MODE_DOWN;
        if (car_floor != '0)
            car_floor--;
        car_result.floor_report_valid = 1'b1;
    endfunction

    function automatic void enter_emergency();
        car_mode = MODE_EMERG;
        car_result.motor_cmd = MOTOR_BRAKE;
        car_result.brake_engaged = 1'b1;
    endfunction

    function automatic void brake_in_motion();
        tr_on = 1'b0;
        dep_on = 1'b0;
        enter_emergency();
    endfunction

    function automatic void take_goal(input logic [REQ_W-1:0] f);
        if (f < FLOOR_COUNT)
            car_goal = f[FLOOR_W-1:0];
    endfunction

    function automatic void apply_tick();
        bit wd_fire;
        bit dep_fire;
        bit tr_fire;
        wd_fire  = timer_expired(wd_cnt, wd_on, cfg_wd);
        dep_fire = timer_expired(dep_cnt, dep_on, cfg_dep);
        tr_fire  = timer_expired(tr_cnt, tr_on, cfg_tr);
        if (wd_fire)
        begin
            wd_on = 1'b0;
            if (car_mode == MODE_STOP)
            begin
                dep_on = 1'b0;
                enter_emergency();
            end
        end
        if (dep_fire && dep_on && car_mode == MODE_STOP)
        begin
            if (car_goal > car_floor)
            begin
                tr_cnt = '0;
                tr_on = 1'b1;
                car_result.motor_cmd = MOTOR_UP;
                step_up();
            end
            else if (car_goal < car_floor)
            begin
                tr_cnt = '0;
                tr_on = 1'b1;
                car_result.motor_cmd = MOTOR_DOWN;
                step_down();
            end
        end
        if (tr_fire && tr_on && car_moving())
        begin
            if (car_floor == car_goal)
            begin
                tr_on = 1'b0;
                car_result.motor_cmd = MOTOR_STOP;
                car_result.arrived = 1'b1;
                enter_stopped_mode();
            end
            else if (car_mode == MODE_UP)
                step_up();
            else
                step_down();
        end
    endfunction

    function automatic ecc_result_t predict_item(input logic [KIND_W-1:0] k,
                                                 input logic [REQ_W-1:0] f);
        car_result = '0;
        // The first item after reset is preceded by the entry into the stopped mode.
        if (!powered_up)
        begin
            powered_up = 1'b1;
            enter_stopped_mode();
        end
        case (k)
            KIND_TICK:
                apply_tick();
            KIND_DOOR_OPENED:
                if (car_mode == MODE_STOP)
                begin
                    if (door_pending)
                    begin
                        wd_on = 1'b0;
                        car_mode = MODE_DOORS;
                    end
                end
                else if (car_moving())
                    brake_in_motion();
            KIND_DOOR_CLOSED:
                if (car_mode == MODE_DOORS)
                    enter_stopped_mode();
            KIND_NEW_TARGET:
                if (car_mode == MODE_STOP)
                begin
                    take_goal(f);
                    goal_fresh = 1'b1;
                    enter_stopped_mode();
                end
                else if (car_mode == MODE_UP)
                begin
                    take_goal(f);
                    step_up();
                end
                else if (car_mode == MODE_DOWN)
                begin
                    take_goal(f);
                    step_down();
                end
                else if (car_mode == MODE_DOORS)
                    take_goal(f);
            KIND_OPEN_DOORS:
                if (car_mode == MODE_STOP)
                    enter_stopped_mode();
            KIND_TEST_OPEN:
                if (car_moving())
                    brake_in_motion();
            default:
                ;
        endcase
        car_result.reported_floor = car_floor;
        car_result.mode_now = car_mode;
        return car_result;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [REQ_W-1:0] pick_floor();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return REQ_W'($urandom_range(FLOOR_COUNT, 255));
        if (r < 22)
            return '0;
        if (r < 34)
            return REQ_W'(TOP_FLOOR);
        return REQ_W'($urandom_range(0, FLOOR_COUNT - 1));
    endfunction

    // A tick now would let the door watchdog expire in the stopped mode, which
    // locks the car in emergency for the rest of the run.
    function automatic bit tick_unsafe();
        int limit;
        limit = (cfg_wd == '0) ? 1 : int'(cfg_wd);
        return car_mode == MODE_STOP && wd_on && int'(wd_cnt) + 1 >= limit;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        ecc_result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: result with no item pending, expected none, got mode %0d floor %0d",
                     $time, res_if.mode_now, res_if.reported_floor);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("motor_cmd", 8'(want.motor_cmd), 8'(res_if.motor_cmd));
            check_field("door_open_cmd", 8'(want.door_open_cmd), 8'(res_if.door_open_cmd));
            check_field("floor_report_valid", 8'(want.floor_report_valid),
                        8'(res_if.floor_report_valid));
            check_field("reported_floor", 8'(want.reported_floor),
                        8'(res_if.reported_floor));
            check_field("arrived", 8'(want.arrived), 8'(res_if.arrived));
            check_field("brake_engaged", 8'(want.brake_engaged), 8'(res_if.brake_engaged));
            check_field("mode_now", 8'(want.mode_now), 8'(res_if.mode_now));
        end
    endtask

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [REQ_W-1:0] f);
        int gap;
        gap = (steady || rush) ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind <= k;
        req_if.requested_floor <= f;
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_results.push_back(predict_item(k, f));
    endtask

    // Picks an item that keeps the car cycling through its normal modes, with
    // some noise that never brakes the car.
    task automatic send_plausible();
        int                 r;
        int                 lo;
        logic [KIND_W-1:0]  k;
        logic [REQ_W-1:0]   f;
        r = $urandom_range(0, 99);
        f = pick_floor();
        k = KIND_TICK;
        case (car_mode)
            MODE_STOP:
                if (tick_unsafe())
                    k = door_pending ? KIND_DOOR_OPENED : KIND_OPEN_DOORS;
                else if (r < 60)
                    k = KIND_TICK;
                else if (r < 72)
                    k = door_pending ? KIND_DOOR_OPENED : KIND_TICK;
                else if (r < 84)
                    k = KIND_NEW_TARGET;
                else if (r < 88)
                    k = KIND_OPEN_DOORS;
                else
                    k = KIND_W'($urandom_range(0, 7));
            MODE_UP, MODE_DOWN:
                if (r < 80)
                    k = KIND_TICK;
                else if (r < 92)
                begin
                    // A goal the car can still reach after the extra step.
                    k = KIND_NEW_TARGET;
                    if (car_mode == MODE_UP)
                    begin
                        lo = int'(car_floor) + 1;
                        if (lo > int'(TOP_FLOOR))
                            lo = int'(TOP_FLOOR);
                        f = REQ_W'($urandom_range(int'(TOP_FLOOR), lo));
                    end
                    else
                    begin
                        lo = (car_floor == '0) ? 0 : int'(car_floor) - 1;
                        f = REQ_W'($urandom_range(lo, 0));
                    end
                end
                else
                    k = KIND_W'($urandom_range(0, 7));
            MODE_DOORS:
                if (r < 55)
                    k = KIND_DOOR_CLOSED;
                else if (r < 70)
                    k = KIND_NEW_TARGET;
                else if (r < 85)
                    k = KIND_TICK;
                else
                    k = KIND_W'($urandom_range(0, 7));
            default:
                k = KIND_W'($urandom_range(0, 7));
        endcase
        if (car_moving() && (k == KIND_DOOR_OPENED || k == KIND_TEST_OPEN))
            k = ($urandom_range(0, 1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
        if (k == KIND_TICK && tick_unsafe())
            k = KIND_SPARE_B;
        send_item(k, f);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_DEPARTURE_PERIOD: cfg_dep = value;
            REG_TRAVEL_PERIOD:    cfg_tr = value;
            REG_DOOR_ACK_TIMEOUT: cfg_wd = value;
            default:              ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] dep, input logic [CFG_W-1:0] tr,
                             input logic [CFG_W-1:0] wd);
        wait_idle();
        write_reg(REG_DEPARTURE_PERIOD, dep);
        write_reg(REG_TRAVEL_PERIOD, tr);
        write_reg(REG_DOOR_ACK_TIMEOUT, wd);
        cfg_write <= 1'b0;
    endtask

    // Reset periods are far too long for any timer to fire here, so only the
    // events and the entry into the stopped mode on the first item act.
    task automatic test_events_at_rest();
        send_item(KIND_TICK, 8'd0);
        send_item(KIND_SPARE_A, 8'hFF);
        send_item(KIND_SPARE_B, 8'h00);
        send_item(KIND_DOOR_CLOSED, 8'hAA);
        send_item(KIND_NEW_TARGET, 8'd200);
        send_item(KIND_NEW_TARGET, 8'd255);
        send_item(KIND_OPEN_DOORS, 8'h55);
        send_item(KIND_OPEN_DOORS, 8'd0);
        send_item(KIND_TEST_OPEN, 8'd0);
        send_item(KIND_DOOR_OPENED, 8'd0);
        send_item(KIND_NEW_TARGET, 8'd2);
        send_item(KIND_OPEN_DOORS, 8'd0);
        send_item(KIND_TICK, 8'd0);
        send_item(KIND_DOOR_CLOSED, 8'd0);
        send_item(KIND_DOOR_OPENED, 8'd0);
    endtask

    // Up two floors, arrival, then down with a goal change while moving that
    // drives the floor against its bottom end.
    task automatic test_floor_travel();
        configure(16'd1, 16'd1, CFG_MAX);
        send_item(KIND_TICK, 8'd0);
        send_item(KIND_TICK, 8'd0);
        send_item(KIND_TICK, 8'd0);
        send_item(KIND_DOOR_OPENED, 8'd0);
        send_item(KIND_NEW_TARGET, 8'd1);
        send_item(KIND_DOOR_CLOSED, 8'd0);
        send_item(KIND_TICK, 8'd0);
        send_item(KIND_NEW_TARGET, 8'd0);
        send_item(KIND_NEW_TARGET, 8'd0);
        send_item(KIND_TICK, 8'd0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: configure(16'd0, 16'd1, 16'd1);
                1: configure(16'd2, 16'd3, 16'd10);
                2: configure(CFG_MAX, CFG_MAX, 16'd5);
                default:
                    configure(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 6)),
                              CFG_W'($urandom_range(4, 24)));
            endcase
            steady = (phase == 4);
            repeat ((phase == 2) ? 40 : 170) send_plausible();
        end
        steady = 1'b0;
    endtask

    // The result side holds off while items keep coming, so the block must
    // fill up and stop taking items.
    task automatic test_output_backpressure();
        configure(16'd3, 16'd2, 16'd16);
        rush = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_plausible();
        rush = 1'b0;
    endtask

    // Emergency is never left, so it comes last, by one of its three routes.
    task automatic test_emergency();
        int route;
        int guard;
        route = $urandom_range(ROUTE_WATCHDOG, ROUTE_TEST_OPEN);
        guard = 0;
        configure(16'd1, 16'd1, (route == ROUTE_WATCHDOG) ? 16'd3 : CFG_MAX);
        while (car_mode != MODE_EMERG && guard < 300)
        begin
            guard++;
            case (car_mode)
                MODE_DOORS:
                    send_item(KIND_DOOR_CLOSED, 8'd0);
                MODE_UP, MODE_DOWN:
                    if (route == ROUTE_DOOR_OPEN)
                        send_item(KIND_DOOR_OPENED, pick_floor());
                    else if (route == ROUTE_TEST_OPEN)
                        send_item(KIND_TEST_OPEN, pick_floor());
                    else if (car_floor == car_goal)
                        send_item(KIND_TICK, 8'd0);
                    else if (car_mode == MODE_UP)
                        send_item(KIND_NEW_TARGET,
                                  REQ_W'((car_floor == TOP_FLOOR) ? car_floor : car_floor + 1));
                    else
                        send_item(KIND_NEW_TARGET,
                                  REQ_W'((car_floor == '0) ? car_floor : car_floor - 1));
                default:
                    if (route == ROUTE_WATCHDOG)
                        send_item((door_pending && wd_on) ? KIND_TICK : KIND_OPEN_DOORS, 8'd0);
                    else if (car_goal == car_floor)
                        send_item(KIND_NEW_TARGET,
                                  (car_floor < FLOOR_COUNT / 2) ? REQ_W'(TOP_FLOOR) : '0);
                    else
                        send_item(KIND_TICK, 8'd0);
            endcase
        end
        for (int k = 0; k < 8; k++)
            send_item(KIND_W'(k), pick_floor());
        repeat (6) send_item(KIND_TICK, pick_floor());
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                check_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (steady)
                res_if.ready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                res_if.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int waited;
        waited = 0;
        reset_car_model();
        req_if.valid = 1'b0;
        req_if.kind = KIND_TICK;
        req_if.requested_floor = '0;
        cfg_write = 1'b0;
        cfg_index = REG_DEPARTURE_PERIOD;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_events_at_rest();
        test_floor_travel();
        test_random_traffic();
        test_output_backpressure();
        test_emergency();

        req_if.valid <= 1'b0;
        steady = 1'b1;
        while (expected_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
